// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the degree sine block.
// Defining ASSERT_OFF removes every assertion body; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/dsin_pkg.sv -----
// Shared types, constants and the microcode table of the degree sine block.
// Used by dsin_div, dsin_mul and degree_sine_taylor_series; no dependencies.
`default_nettype none

package dsin_pkg;

	// Angle constants in 1/256 degree.
	localparam logic [16:0] DEG_FULL    = 17'd92160;
	localparam logic [16:0] DEG_HALF    = 17'd46080;
	localparam logic [16:0] DEG_QUARTER = 17'd23040;
	localparam logic [16:0] DEG_THREEQ  = 17'd69120;

	// Degrees to radians: deg256 * PI_NUM / RAD_DEN.
	localparam logic [14:0] PI_NUM  = 15'd31416;
	localparam logic [28:0] RAD_DEN = 29'd460800000;

	// Divisor width of the shared divider, set by RAD_DEN.
	localparam int DVS_W = 29;

	// The 24-bit angle magnitude goes through the divider two bits a step.
	localparam int MOD_PAIRS = 12;

	// Full scale of the Q16 result.
	localparam logic [16:0] SAT_MAG = 17'h10000;

	localparam int PC_W = 4;

	localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] STEP_MOD   = 4'd1;
	localparam logic [PC_W-1:0] STEP_MOD_W = 4'd2;
	localparam logic [PC_W-1:0] STEP_FOLD  = 4'd3;
	localparam logic [PC_W-1:0] STEP_RAD   = 4'd4;
	localparam logic [PC_W-1:0] STEP_RAD_W = 4'd5;
	localparam logic [PC_W-1:0] STEP_SQ    = 4'd6;
	localparam logic [PC_W-1:0] STEP_SQ_W  = 4'd7;
	localparam logic [PC_W-1:0] STEP_ACCUM = 4'd8;
	localparam logic [PC_W-1:0] STEP_MUL   = 4'd9;
	localparam logic [PC_W-1:0] STEP_MUL_W = 4'd10;
	localparam logic [PC_W-1:0] STEP_DIV   = 4'd11;
	localparam logic [PC_W-1:0] STEP_DIV_W = 4'd12;
	localparam logic [PC_W-1:0] STEP_ABS   = 4'd13;
	localparam logic [PC_W-1:0] STEP_ROUND = 4'd14;
	localparam logic [PC_W-1:0] STEP_EMIT  = 4'd15;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD_IN,
		ACT_DIV_MOD,
		ACT_TAKE_MOD,
		ACT_FOLD,
		ACT_DIV_RAD,
		ACT_TAKE_RAD,
		ACT_MUL_SQ,
		ACT_TAKE_SQ,
		ACT_ACCUM,
		ACT_MUL_TERM,
		ACT_TAKE_PROD,
		ACT_DIV_TERM,
		ACT_TAKE_TERM,
		ACT_ABS,
		ACT_ROUND
	} act_t;

	typedef enum logic [2:0] {
		W_NONE,
		W_INPUT,
		W_DIV,
		W_MUL,
		W_OUT
	} wait_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_ALWAYS,
		J_STOP
	} jump_t;

	typedef struct packed {
		act_t            act;
		wait_t           wt;
		jump_t           jmp;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	// Status of a multi-cycle arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Control store. A step holds until its wait condition is met, then
	// performs its action and moves on.
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t cw;
		cw = '{ACT_NONE, W_NONE, J_NEXT, STEP_IDLE};
		case (pc)
			STEP_IDLE:  cw = '{ACT_LOAD_IN,   W_INPUT, J_NEXT,   STEP_IDLE};
			STEP_MOD:   cw = '{ACT_DIV_MOD,   W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_MOD_W: cw = '{ACT_TAKE_MOD,  W_DIV,   J_NEXT,   STEP_IDLE};
			STEP_FOLD:  cw = '{ACT_FOLD,      W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_RAD:   cw = '{ACT_DIV_RAD,   W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_RAD_W: cw = '{ACT_TAKE_RAD,  W_DIV,   J_NEXT,   STEP_IDLE};
			STEP_SQ:    cw = '{ACT_MUL_SQ,    W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_SQ_W:  cw = '{ACT_TAKE_SQ,   W_MUL,   J_NEXT,   STEP_IDLE};
			STEP_ACCUM: cw = '{ACT_ACCUM,     W_NONE,  J_STOP,   STEP_ABS};
			STEP_MUL:   cw = '{ACT_MUL_TERM,  W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_MUL_W: cw = '{ACT_TAKE_PROD, W_MUL,   J_NEXT,   STEP_IDLE};
			STEP_DIV:   cw = '{ACT_DIV_TERM,  W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_DIV_W: cw = '{ACT_TAKE_TERM, W_DIV,   J_ALWAYS, STEP_ACCUM};
			STEP_ABS:   cw = '{ACT_ABS,       W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_ROUND: cw = '{ACT_ROUND,     W_NONE,  J_NEXT,   STEP_IDLE};
			STEP_EMIT:  cw = '{ACT_NONE,      W_OUT,   J_ALWAYS, STEP_IDLE};
			default:    cw = '{ACT_NONE,      W_NONE,  J_ALWAYS, STEP_IDLE};
		endcase
		return cw;
	endfunction

	// Series divisor (2k)(2k+1) for term index k.
	function automatic logic [8:0] term_div(input logic [3:0] k);
		logic [8:0] k2;
		k2 = {4'b0, k, 1'b0};
		return 9'(k2 * (k2 + 9'd1));
	endfunction

endpackage

`default_nettype wire

// ----- hdl/dsin_div.sv -----
// Shared restoring divider of the degree sine block, two quotient bits a cycle.
// Depends on dsin_pkg for the divisor width and the status struct.
`default_nettype none

module dsin_div #(
	parameter int DIVW = 62,
	parameter int PW   = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DIVW-1:0]               dividend,
	input  wire logic [dsin_pkg::DVS_W-1:0]    divisor,
	input  wire logic [PW-1:0]                 pairs,
	output      logic [DIVW-1:0]               quotient,
	output      logic [dsin_pkg::DVS_W-1:0]    remainder,
	output      dsin_pkg::unit_stat_t          stat
);

	localparam int VW = dsin_pkg::DVS_W;

	logic [PW-1:0]   cnt_q;
	logic            done_q;
	logic [DIVW-1:0] dvd_q;
	logic [DIVW-1:0] quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;

	logic [VW:0]   t1, t2;
	logic          ge1, ge2;
	logic [VW-1:0] r1, r2;

	// The dividend enters at its top; each cycle retires two bits.
	always_comb begin
		t1  = {rem_q, dvd_q[DIVW-1]};
		ge1 = t1 >= {1'b0, dvs_q};
		r1  = ge1 ? VW'(t1 - {1'b0, dvs_q}) : VW'(t1);
		t2  = {r1, dvd_q[DIVW-2]};
		ge2 = t2 >= {1'b0, dvs_q};
		r2  = ge2 ? VW'(t2 - {1'b0, dvs_q}) : VW'(t2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= pairs;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - PW'(1);
			done_q <= cnt_q == PW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 2;
			quo_q <= {quo_q[DIVW-3:0], ge1, ge2};
			rem_q <= r2;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- hdl/dsin_mul.sv -----
// Chunked fixed-point multiplier of the degree sine block: 16 bits of b a cycle,
// result rounded half up at FB fraction bits. Depends on dsin_pkg.
`default_nettype none

module dsin_mul #(
	parameter int WW = 33,
	parameter int FB = 30
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [WW-1:0] a,
	input  wire logic [WW-1:0] b,
	output      logic [WW-1:0] result,
	output      dsin_pkg::unit_stat_t stat
);

	localparam int CH = (WW + 15) / 16;
	localparam int BW = CH * 16;
	localparam int AW = WW + BW;
	localparam int CW = $clog2(CH + 1);

	logic [CW-1:0]   cnt_q;
	logic            pv_s1;
	logic            last_s1;
	logic            done_q;
	logic [WW-1:0]   a_q;
	logic [BW-1:0]   b_q;
	logic [WW+15:0]  pp_s1;
	logic [AW-1:0]   acc_q;
	logic [WW+15:0]  pp_w;
	logic [AW-1:0]   rnd_w;

	// Most significant chunk first, so the accumulator only ever shifts left.
	assign pp_w = (WW+16)'(a_q) * (WW+16)'(b_q[BW-1 -: 16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else if (start) begin
			cnt_q   <= CW'(CH);
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pv_s1   <= cnt_q != '0;
			last_s1 <= cnt_q == CW'(1);
			done_q  <= pv_s1 && last_s1;
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BW'(b);
			acc_q <= '0;
		end else begin
			if (cnt_q != '0) begin
				pp_s1 <= pp_w;
				b_q   <= b_q << 16;
			end
			if (pv_s1) begin
				acc_q <= (acc_q << 16) + AW'(pp_s1);
			end
		end
	end

	assign rnd_w     = acc_q + (AW'(1) << (FB - 1));
	assign result    = WW'(rnd_w >> FB);
	assign stat.busy = (cnt_q != '0) || pv_s1;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- hdl/degree_sine_taylor_series.sv -----
// Top level of the degree sine block: microcode sequencer and datapath.
// Depends on dsin_pkg, dsin_div, dsin_mul and assert_macros.svh.
//
// Usage. An item on the input channel (in_valid, in_stall, angle_deg) is a
// signed angle in 1/256 degree. For each item the block returns one item on
// the output channel (out_valid, out_stall, sine_value, terms_used): the sine
// in signed Q16 and the number of Taylor terms that were summed. An item is
// taken at a clock edge where valid is high and stall is low.
// Sequencing: one item is worked on at a time. A short program in a control
// store steps a shared 2-bit-per-cycle divider and a 16-bit-chunked
// multiplier; the divider sets the time. Each term after the first adds a
// multiply and a divide. The next item is accepted as soon as the sequencer
// is back at its first step, even while the previous result is still held.
// A stalled result stays in the output register, unchanged; the sequencer
// waits only when a new result is ready and the register is still full.
// term_threshold is to be written by the user through cfg_wr_en and
// cfg_wr_data only while idle; the block itself does not enforce this.
// Reset (arst_n low) returns the sequencer to its first step, empties the
// output register and sets the threshold back to 7.
`default_nettype none
`include "assert_macros.svh"

module degree_sine_taylor_series #(
	parameter int MAX_TERMS      = 8,
	parameter int WORK_FRAC_BITS = 30
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [15:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic signed [23:0] angle_deg,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic signed [17:0] sine_value,
	output      logic [3:0]         terms_used
);

	// Working width: terms, x^2 and the signed partial sum all stay below
	// four in magnitude, so three integer bits cover them.
	localparam int FB         = WORK_FRAC_BITS;
	localparam int WW         = FB + 3;
	// The degree-to-radian division has a dividend of FB+31 bits.
	localparam int DIV_PAIRS  = (FB + 32) / 2;
	localparam int DIVW       = 2 * DIV_PAIRS;
	localparam int TERM_PAIRS = (FB + 4) / 2;
	localparam int TDW        = 2 * TERM_PAIRS;
	localparam int PW         = $clog2(DIV_PAIRS + 1);
	localparam int VW         = dsin_pkg::DVS_W;
	// Rounding constant of the Q16 result; there is none at 16 fraction bits.
	localparam logic [WW-1:0] RND_HALF =
		(FB > 16) ? (WW'(1) << ((FB > 16) ? FB - 17 : 0)) : '0;

	logic [dsin_pkg::PC_W-1:0] pc_q, pc_nx;
	dsin_pkg::ctrl_word_t      cw;
	logic                      go;
	logic                      stop;

	logic [15:0]   thr_q;
	logic [23:0]   mag_q;
	logic          neg_q;
	logic [16:0]   r_q;
	logic [WW-1:0] term_q;
	logic [WW-1:0] x2_q;
	logic [WW-1:0] t_q;
	logic [WW-1:0] sum_q;
	logic [WW-1:0] smag_q;
	logic [3:0]    cnt_q;
	logic [16:0]   q_q;

	logic               out_valid_q;
	logic signed [17:0] sine_value_q;
	logic [3:0]         terms_used_q;

	logic [WW-1:0] thr_w;
	logic [3:0]    cnt_nx;
	logic [31:0]   rad_prod;
	logic [8:0]    tdiv;
	logic [WW-1:0] rnd_w;
	logic [WW-1:0] rad_q_w;

	logic                 div_start;
	logic [DIVW-1:0]      div_dvd;
	logic [VW-1:0]        div_dvs;
	logic [PW-1:0]        div_pairs;
	logic [DIVW-1:0]      div_quo;
	logic [VW-1:0]        div_rem;
	dsin_pkg::unit_stat_t div_st;

	logic                 mul_start;
	logic [WW-1:0]        mul_a;
	logic [WW-1:0]        mul_b;
	logic [WW-1:0]        mul_res;
	dsin_pkg::unit_stat_t mul_st;

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	assign cw = dsin_pkg::ucode(pc_q);

	// The series stops once a term is at or below the threshold, or once
	// the count reaches its limit.
	assign thr_w  = WW'(thr_q) << (FB - 16);
	assign cnt_nx = cnt_q + 4'd1;
	assign stop   = (term_q <= thr_w) || (cnt_nx >= 4'(MAX_TERMS));

	always_comb begin
		case (cw.wt)
			dsin_pkg::W_NONE:  go = 1'b1;
			dsin_pkg::W_INPUT: go = in_valid;
			dsin_pkg::W_DIV:   go = div_st.done;
			dsin_pkg::W_MUL:   go = mul_st.done;
			dsin_pkg::W_OUT:   go = !out_valid_q || !out_stall;
			default:           go = 1'b0;
		endcase
		pc_nx = pc_q;
		if (go) begin
			case (cw.jmp)
				dsin_pkg::J_NEXT:   pc_nx = pc_q + dsin_pkg::PC_W'(1);
				dsin_pkg::J_ALWAYS: pc_nx = cw.target;
				dsin_pkg::J_STOP:   pc_nx = stop ? cw.target : pc_q + dsin_pkg::PC_W'(1);
				default:            pc_nx = dsin_pkg::STEP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dsin_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_nx;
		end
	end

	// The only step that takes an item is the one waiting on the input.
	assign in_stall = cw.wt != dsin_pkg::W_INPUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd7;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// ---------------------------------------------------------------------
	// Operand selection for the shared units
	// ---------------------------------------------------------------------
	assign rad_prod = 32'(r_q) * 32'(dsin_pkg::PI_NUM);
	assign tdiv     = dsin_pkg::term_div(cnt_q);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		div_pairs = '0;
		mul_start = 1'b0;
		mul_a     = term_q;
		mul_b     = term_q;
		case (cw.act)
			dsin_pkg::ACT_DIV_MOD: begin
				// The remainder of this division is the angle modulo 360 degrees.
				div_start = go;
				div_dvd   = DIVW'(mag_q) << (DIVW - 24);
				div_dvs   = VW'(dsin_pkg::DEG_FULL);
				div_pairs = PW'(dsin_pkg::MOD_PAIRS);
			end
			dsin_pkg::ACT_DIV_RAD: begin
				// One extra quotient bit is kept for rounding to nearest.
				div_start = go;
				div_dvd   = DIVW'(rad_prod[29:0]) << (FB + 1);
				div_dvs   = dsin_pkg::RAD_DEN;
				div_pairs = PW'(DIV_PAIRS);
			end
			dsin_pkg::ACT_DIV_TERM: begin
				// Adding half the divisor rounds the quotient to nearest.
				div_start = go;
				div_dvd   = DIVW'(t_q + WW'(tdiv >> 1)) << (DIVW - TDW);
				div_dvs   = VW'(tdiv);
				div_pairs = PW'(TERM_PAIRS);
			end
			dsin_pkg::ACT_MUL_SQ: begin
				mul_start = go;
			end
			dsin_pkg::ACT_MUL_TERM: begin
				mul_start = go;
				mul_b     = x2_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	dsin_div #(
		.DIVW(DIVW),
		.PW  (PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.pairs    (div_pairs),
		.quotient (div_quo),
		.remainder(div_rem),
		.stat     (div_st)
	);

	dsin_mul #(
		.WW(WW),
		.FB(FB)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.result(mul_res),
		.stat  (mul_st)
	);

	// ---------------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------------
	assign rad_q_w = div_quo[WW-1:0] + WW'(1);
	assign rnd_w   = (smag_q + RND_HALF) >> (FB - 16);

	always_ff @(posedge clk) begin
		if (go) begin
			case (cw.act)
				dsin_pkg::ACT_LOAD_IN: begin
					// The most negative angle keeps its magnitude in 24 bits.
					mag_q <= angle_deg[23] ? 24'(-angle_deg) : 24'(angle_deg);
					neg_q <= angle_deg[23];
					sum_q <= '0;
					cnt_q <= '0;
				end
				dsin_pkg::ACT_TAKE_MOD: begin
					r_q <= div_rem[16:0];
				end
				dsin_pkg::ACT_FOLD: begin
					// Fold into 0..90 degrees. Exactly 180 maps to zero with a
					// positive sign, and exactly 270 to 90 with a negative one.
					if (r_q > dsin_pkg::DEG_THREEQ) begin
						r_q   <= dsin_pkg::DEG_FULL - r_q;
						neg_q <= !neg_q;
					end else if (r_q > dsin_pkg::DEG_HALF) begin
						r_q   <= r_q - dsin_pkg::DEG_HALF;
						neg_q <= !neg_q;
					end else if (r_q > dsin_pkg::DEG_QUARTER) begin
						r_q <= dsin_pkg::DEG_HALF - r_q;
					end
				end
				dsin_pkg::ACT_TAKE_RAD: begin
					term_q <= rad_q_w >> 1;
				end
				dsin_pkg::ACT_TAKE_SQ: begin
					x2_q <= mul_res;
				end
				dsin_pkg::ACT_ACCUM: begin
					// Odd-numbered terms are subtracted.
					sum_q <= cnt_q[0] ? sum_q - term_q : sum_q + term_q;
					cnt_q <= cnt_nx;
				end
				dsin_pkg::ACT_TAKE_PROD: begin
					t_q <= mul_res;
				end
				dsin_pkg::ACT_TAKE_TERM: begin
					term_q <= div_quo[WW-1:0];
				end
				dsin_pkg::ACT_ABS: begin
					// A negative sum flips the sign, so rounding works on magnitude.
					smag_q <= sum_q[WW-1] ? -sum_q : sum_q;
					neg_q  <= neg_q ^ sum_q[WW-1];
				end
				dsin_pkg::ACT_ROUND: begin
					q_q <= (rnd_w > WW'(dsin_pkg::SAT_MAG)) ? dsin_pkg::SAT_MAG : rnd_w[16:0];
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && cw.wt == dsin_pkg::W_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && cw.wt == dsin_pkg::W_OUT) begin
			sine_value_q <= neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
			terms_used_q <= cnt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sine_value = sine_value_q;
	assign terms_used = terms_used_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`ASSERT_IMPLY(a_div_done_awaited, clk, arst_n, div_st.done, cw.wt == dsin_pkg::W_DIV)
	`ASSERT_IMPLY(a_mul_done_awaited, clk, arst_n, mul_st.done, cw.wt == dsin_pkg::W_MUL)
	`ASSERT_NEVER(a_div_overlap, clk, arst_n, div_start && div_st.busy)
	`ASSERT_IMPLY(a_terms_range, clk, arst_n, out_valid_q, (terms_used_q != 4'd0) && (terms_used_q <= 4'(MAX_TERMS)))

endmodule

`default_nettype wire
